/* design/cpws_pkg.sv */
// ----------------------------------------------------------------------------
// cpws_pkg
// Shared types and constants of the class priority window scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpws_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int CLS_W           = 2;
    localparam int TAG_BITS        = 16;
    localparam int PRIO_W          = 4;
    localparam int WIN_W           = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WINDOW_CAP_DEF  = 10;
    localparam int CMDQ_DEPTH      = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_FIELD_W = CLS_W + TAG_BITS + 1;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = TAG_BITS + CLS_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITIES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELIABLE_MASK = 3'd3;

    typedef enum logic
    {
        CMD_ENQ,
        CMD_FB
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t            kind;
        logic [CLS_W-1:0]     cls;
        logic [TAG_BITS-1:0]  tag;
        logic                 success;
    } cmd_t;

    typedef struct packed
    {
        logic [NUM_CLASSES-1:0]        enable;
        logic [NUM_CLASSES*PRIO_W-1:0] prio;
        logic [NUM_CLASSES-1:0]        reliable;
        logic                          win_load;
        logic [NUM_CLASSES*WIN_W-1:0]  win_init;
    } cfg_t;

    typedef struct packed
    {
        logic [TAG_BITS-1:0] tag;
        logic [CLS_W-1:0]    cls;
        logic                fec;
        logic                dropped;
        logic                last;
    } result_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_DROP,
        ST_PICK,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* design/class_priority_window_scheduler_top.sv */
// ----------------------------------------------------------------------------
// class_priority_window_scheduler_top
// A feedback word is applied in the engine's EXEC state. An enqueue passes
// EXEC, PICK and READ before EMIT registers its first result; a drop passes
// EXEC before DROP registers its result. An enqueue holds the engine in PICK
// per class and READ and EMIT per packet, set by the one-port tag memory read
// and output register; a two-word command queue takes input words meanwhile.
// Reset: asynchronous active low; clears queues, windows and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module class_priority_window_scheduler_top
    import cpws_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int WINDOW_CAP  = WINDOW_CAP_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: class_id, packet_tag, success, zero padding.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Field: req_type.
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: sent_tag, sent_class, fec_applied, zero padding.
    output logic [M_TDATA_W-1:0]       m_tdata,
    // Field: dropped.
    output logic                       m_tuser,
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NUM_CLASSES-1:0]        enable_reg;
    logic [NUM_CLASSES*PRIO_W-1:0] prio_reg;
    logic [NUM_CLASSES-1:0]        reliable_reg;
    logic                          cfg_write;
    cfg_t                          cfg;
    logic                          cmd_valid;
    cmd_t                          cmd;
    logic                          cmd_pop;
    logic                          out_valid;
    result_t                       out_res;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            prio_reg     <= '0;
            reliable_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENABLE_MASK:   enable_reg   <= cfg_data[NUM_CLASSES-1:0];
                REG_PRIORITIES:    prio_reg     <= cfg_data[NUM_CLASSES*PRIO_W-1:0];
                REG_RELIABLE_MASK: reliable_reg <= cfg_data[NUM_CLASSES-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.enable   = enable_reg;
        cfg.prio     = prio_reg;
        cfg.reliable = reliable_reg;
        cfg.win_load = cfg_write && (cfg_index == REG_INIT_WINDOWS);
        cfg.win_init = cfg_data[NUM_CLASSES*WIN_W-1:0];
    end

    cpws_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cpws_engine
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WINDOW_CAP  (WINDOW_CAP)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .out_ready (m_tready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}}, out_res.fec, out_res.cls, out_res.tag};
    assign m_tuser  = out_res.dropped;
    assign m_tlast  = out_res.last;

endmodule

`default_nettype wire

/* design/cpws_front.sv */
// ----------------------------------------------------------------------------
// cpws_front
// Accepts input words, classifies them as enqueue or feedback commands and
// holds them in a short command queue for the scheduling engine.
// ----------------------------------------------------------------------------
`default_nettype none

module cpws_front
    import cpws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      cmd_valid,
    output cmd_t                      cmd,
    input  wire logic                 cmd_pop
);

    localparam int QPTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(CMDQ_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(CMDQ_DEPTH);

    cmd_t              entry_reg [CMDQ_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    cmd_t              in_cmd;

    always_comb
    begin
        in_cmd.kind    = s_tuser ? CMD_FB : CMD_ENQ;
        in_cmd.cls     = s_tdata[CLS_W-1:0];
        in_cmd.tag     = s_tdata[CLS_W +: TAG_BITS];
        in_cmd.success = s_tdata[CLS_W + TAG_BITS];
    end

    assign s_tready  = (count_reg != QCNT_FULL);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/cpws_engine.sv */
// ----------------------------------------------------------------------------
// cpws_engine
// Keeps the class FIFOs and windows, applies feedback, and runs the strict
// priority scheduling pass that sends packets into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpws_engine
    import cpws_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int WINDOW_CAP  = WINDOW_CAP_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    input  wire cfg_t cfg,
    input  wire logic out_ready,
    output logic      out_valid,
    output result_t   out_res
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES << PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [WIN_W-1:0] WIN_CAP  = WIN_W'(WINDOW_CAP);
    localparam logic [WIN_W-1:0] WIN_ONE  = WIN_W'(1);

    logic [TAG_BITS-1:0] mem [MEM_DEPTH];

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cmd_reg;
    logic [CLS_W-1:0]       cur_reg;
    logic [NUM_CLASSES-1:0] visited_reg;
    logic [WIN_W-1:0]       sent_reg;
    logic                   last_reg;
    logic [PTR_W-1:0]       head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]       tail_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]       count_reg [NUM_CLASSES];
    logic [WIN_W-1:0]       win_reg   [NUM_CLASSES];
    logic [TAG_BITS-1:0]    rd_data_reg;
    logic                   out_valid_reg;
    result_t                out_res_reg;

    logic [PTR_W-1:0]       cur_head;
    logic [PTR_W-1:0]       cur_tail;
    logic [CNT_W-1:0]       cur_count;
    logic [WIN_W-1:0]       cur_win;
    logic [WIN_W-1:0]       fb_win;
    logic [NUM_CLASSES-1:0] cand;
    logic                   pick_valid;
    logic [CLS_W-1:0]       pick_cls;
    logic [PRIO_W-1:0]      pick_prio;
    logic                   queue_full;
    logic                   more_now;
    logic                   more_after;
    logic                   out_free;

    logic do_fb;
    logic do_enq;
    logic do_pick;
    logic do_read;
    logic do_emit;
    logic do_drop;

    assign cur_head  = head_reg[cur_reg];
    assign cur_tail  = tail_reg[cur_reg];
    assign cur_count = count_reg[cur_reg];
    assign cur_win   = win_reg[cur_reg];

    assign queue_full = (cur_count == CNT_FULL);
    assign more_now   = (cur_count != '0) && (sent_reg < cur_win);
    assign more_after = (cur_count != CNT_ONE)
                        && ({1'b0, sent_reg} + 1'b1 < {1'b0, cur_win});
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd_reg.success)
        begin
            fb_win = (cur_win >= WIN_CAP) ? WIN_CAP : cur_win + 1'b1;
        end
        else
        begin
            fb_win = ((cur_win >> 1) == '0) ? WIN_ONE : (cur_win >> 1);
        end
    end

    always_comb
    begin
        pick_valid = 1'b0;
        pick_cls   = '0;
        pick_prio  = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            cand[c] = cfg.enable[c] && !visited_reg[c]
                      && (count_reg[c] != '0) && (win_reg[c] != '0);
            if (cand[c] && (!pick_valid || (cfg.prio[PRIO_W*c +: PRIO_W] < pick_prio)))
            begin
                pick_valid = 1'b1;
                pick_cls   = CLS_W'(c);
                pick_prio  = cfg.prio[PRIO_W*c +: PRIO_W];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg.kind == CMD_FB)
                begin
                    state_next = ST_IDLE;
                end
                else if (queue_full)
                begin
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_PICK;
                end
            end
            ST_DROP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PICK:
            begin
                state_next = pick_valid ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = more_now ? ST_READ : ST_PICK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
        do_fb   = (state_reg == ST_EXEC) && (cmd_reg.kind == CMD_FB);
        do_enq  = (state_reg == ST_EXEC) && (cmd_reg.kind == CMD_ENQ) && !queue_full;
        do_pick = (state_reg == ST_PICK) && pick_valid;
        do_read = (state_reg == ST_READ);
        do_emit = (state_reg == ST_EMIT) && out_free;
        do_drop = (state_reg == ST_DROP) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            visited_reg   <= '0;
            sent_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
                win_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                cur_reg <= cmd.cls;
            end
            if (cfg.win_load)
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    win_reg[c] <= (cfg.win_init[WIN_W*c +: WIN_W] > WIN_CAP)
                                  ? WIN_CAP : cfg.win_init[WIN_W*c +: WIN_W];
                end
            end
            else if (do_fb)
            begin
                win_reg[cur_reg] <= fb_win;
            end
            if (do_enq)
            begin
                tail_reg[cur_reg]  <= (cur_tail == PTR_LAST) ? '0 : cur_tail + 1'b1;
                count_reg[cur_reg] <= cur_count + 1'b1;
                visited_reg        <= '0;
            end
            if (do_pick)
            begin
                cur_reg               <= pick_cls;
                visited_reg[pick_cls] <= 1'b1;
                sent_reg              <= '0;
            end
            if (do_read)
            begin
                head_reg[cur_reg]  <= (cur_head == PTR_LAST) ? '0 : cur_head + 1'b1;
                count_reg[cur_reg] <= cur_count - 1'b1;
                sent_reg           <= sent_reg + 1'b1;
                last_reg           <= !more_after && !(|cand);
            end
            if (do_emit || do_drop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (do_enq)
        begin
            mem[{cur_reg, cur_tail}] <= cmd_reg.tag;
        end
        if (do_read)
        begin
            rd_data_reg <= mem[{cur_reg, cur_head}];
        end
        if (do_emit)
        begin
            out_res_reg.tag     <= rd_data_reg;
            out_res_reg.cls     <= cur_reg;
            out_res_reg.fec     <= cfg.reliable[cur_reg];
            out_res_reg.dropped <= 1'b0;
            out_res_reg.last    <= last_reg;
        end
        else if (do_drop)
        begin
            out_res_reg.tag     <= cmd_reg.tag;
            out_res_reg.cls     <= cmd_reg.cls;
            out_res_reg.fec     <= 1'b0;
            out_res_reg.dropped <= 1'b1;
            out_res_reg.last    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

/* design/cpws_checker.sv */
// ----------------------------------------------------------------------------
// cpws_checker
// Port-level checks of the scheduler's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpws_checker
    import cpws_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser,
    input wire logic                  m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("Stalled output word changed.");

    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("Drop word is not the last word of its run.");

    a_drop_no_fec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[TAG_BITS + CLS_W])
        else $error("Drop word carries the correction flag.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
        else $error("Output padding bits are not zero.");

endmodule

bind class_priority_window_scheduler_top cpws_checker u_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the class priority window scheduler. A directed
// table covers the empty and zero-window passes, window feedback at the lower
// bound, initial windows above the cap, full-queue drops, priority order
// and ignored register indexes. Random traffic over several register
// settings follows. Every accepted output word is compared with a predictor
// that tracks the queues and windows.
// ----------------------------------------------------------------------------

module tb_top;
    import cpws_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 50;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct
    {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        cmd_kind_t             kind;
        logic [CLS_W-1:0]      cls;
        logic [TAG_BITS-1:0]   tag;
        logic                  ok;
        int                    reps;
        bit                    typed;
        result_t               want;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [TAG_BITS-1:0]   tag_fifo [NUM_CLASSES][$];
    int unsigned           class_win [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] en_mask  = '0;
    logic [NUM_CLASSES-1:0] rel_mask = '0;
    logic [NUM_CLASSES*PRIO_W-1:0] prio_nibbles = '0;

    result_t   pass_words[$];
    result_t   predicted_sends[$];
    plan_row_t plan[$];

    bit idle_on     = 1'b1;
    bit hold_output = 1'b0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int words_in       = 0;
    int feedback_in    = 0;
    int results_out    = 0;
    int drops_out      = 0;
    int reg_writes     = 0;
    int holds_done     = 0;

    class_priority_window_scheduler_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Works out the words that one request sends and updates the queues and windows.
    function automatic void schedule_step(cmd_kind_t kind, logic [CLS_W-1:0] cls,
                                          logic [TAG_BITS-1:0] tag, logic ok);
        int unsigned w;
        int unsigned sent;
        result_t     r;
        pass_words.delete();
        if (kind == CMD_FB)
        begin
            w = class_win[cls];
            if (ok)
                w = (w + 1 > WINDOW_CAP_DEF) ? WINDOW_CAP_DEF : w + 1;
            else
                w = (w / 2 < 1) ? 1 : w / 2;
            class_win[cls] = w;
            return;
        end
        if (tag_fifo[cls].size() >= QUEUE_DEPTH_DEF)
        begin
            r.tag     = tag;
            r.cls     = cls;
            r.fec     = 1'b0;
            r.dropped = 1'b1;
            r.last    = 1'b1;
            pass_words = {pass_words, r};
            return;
        end
        tag_fifo[cls] = {tag_fifo[cls], tag};
        for (int p = 0; p < 16; p++)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (!en_mask[c] || prio_nibbles[PRIO_W*c +: PRIO_W] != p)
                    continue;
                sent = 0;
                while (tag_fifo[c].size() > 0 && sent < class_win[c])
                begin
                    r.tag     = tag_fifo[c].pop_front();
                    r.cls     = CLS_W'(c);
                    r.fec     = rel_mask[c];
                    r.dropped = 1'b0;
                    r.last    = 1'b0;
                    pass_words = {pass_words, r};
                    sent++;
                end
            end
        end
        if (pass_words.size() > 0)
            pass_words[$].last = 1'b1;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row        = '{default: '0, kind: CMD_ENQ, want: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic plan_row_t item_row(cmd_kind_t kind, logic [CLS_W-1:0] cls,
                                           logic [TAG_BITS-1:0] tag, logic ok, int reps);
        plan_row_t row;
        row      = '{default: '0, kind: CMD_ENQ, want: '0};
        row.kind = kind;
        row.cls  = cls;
        row.tag  = tag;
        row.ok   = ok;
        row.reps = reps;
        return row;
    endfunction

    function automatic plan_row_t with_result(plan_row_t row, logic [TAG_BITS-1:0] tag,
                                              logic [CLS_W-1:0] cls, logic fec,
                                              logic dropped);
        row.typed        = 1'b1;
        row.want.tag     = tag;
        row.want.cls     = cls;
        row.want.fec     = fec;
        row.want.dropped = dropped;
        row.want.last    = 1'b1;
        return row;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_word(cmd_kind_t kind, logic [CLS_W-1:0] cls,
                             logic [TAG_BITS-1:0] tag, logic ok, bit typed,
                             result_t want);
        int gap;
        logic [S_TDATA_W-1:0] w;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w = '0;
        w[CLS_W-1:0]              = cls;
        w[CLS_W +: TAG_BITS]      = tag;
        w[CLS_W + TAG_BITS]       = ok;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        schedule_step(kind, cls, tag, ok);
        if (typed)
            predicted_sends = {predicted_sends, want};
        else
            foreach (pass_words[n])
                predicted_sends = {predicted_sends, pass_words[n]};
        words_in++;
        if (kind == CMD_FB)
            feedback_in++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        repeat ($urandom_range(1, 4)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_ENABLE_MASK:   en_mask = data[NUM_CLASSES-1:0];
            REG_PRIORITIES:    prio_nibbles = data[NUM_CLASSES*PRIO_W-1:0];
            REG_INIT_WINDOWS:
                for (int c = 0; c < NUM_CLASSES; c++)
                    class_win[c] = (data[WIN_W*c +: WIN_W] > WINDOW_CAP_DEF) ?
                                   WINDOW_CAP_DEF : data[WIN_W*c +: WIN_W];
            REG_RELIABLE_MASK: rel_mask = data[NUM_CLASSES-1:0];
            default: ;
        endcase
    endtask

    // Registers change only once the engine has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (predicted_sends.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL class_priority_window_scheduler_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int gap;
        result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
                holds_done++;
            end
            gap = idle_on ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_out++;
            if (m_tuser)
                drops_out++;
            if (predicted_sends.size() == 0)
            begin
                $error("unexpected word: sent_tag %h sent_class %0d",
                       m_tdata[TAG_BITS-1:0], m_tdata[TAG_BITS +: CLS_W]);
                mismatch_count++;
            end
            else
            begin
                want = predicted_sends.pop_front();
                if (m_tdata[TAG_BITS-1:0] !== want.tag)
                begin
                    $error("sent_tag: expected %h, actual %h", want.tag,
                           m_tdata[TAG_BITS-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[TAG_BITS +: CLS_W] !== want.cls)
                begin
                    $error("sent_class: expected %0d, actual %0d", want.cls,
                           m_tdata[TAG_BITS +: CLS_W]);
                    mismatch_count++;
                end
                if (m_tdata[TAG_BITS + CLS_W] !== want.fec)
                begin
                    $error("fec_applied: expected %0b, actual %0b", want.fec,
                           m_tdata[TAG_BITS + CLS_W]);
                    mismatch_count++;
                end
                if (m_tuser !== want.dropped)
                begin
                    $error("dropped: expected %0b, actual %0b", want.dropped, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] en_v;
        logic [CFG_DATA_W-1:0] prio_v;
        logic [CFG_DATA_W-1:0] win_v;
        logic [CFG_DATA_W-1:0] rel_v;
        cmd_kind_t kind;

        foreach (class_win[c])
            class_win[c] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset every class is disabled and every window is zero.
        plan = '{
            item_row(CMD_ENQ, 2'd0, 16'h0000, 1'b0, 1),
            cfg_row(REG_ENABLE_MASK, 16'h000F),
            item_row(CMD_ENQ, 2'd1, 16'hFFFF, 1'b0, 1),
            item_row(CMD_FB,  2'd1, 16'h0000, 1'b1, 1),
            with_result(item_row(CMD_ENQ, 2'd1, 16'h5A5A, 1'b0, 1),
                        16'hFFFF, 2'd1, 1'b0, 1'b0),
            item_row(CMD_FB,  2'd1, 16'h0000, 1'b0, 1),
            cfg_row(REG_RELIABLE_MASK, 16'h000F),
            cfg_row(REG_INIT_WINDOWS, 16'hFFFF),
            cfg_row(REG_PRIORITIES, 16'h0123),
            cfg_row(REG_SPARE_FIRST, 16'hFFFF),
            cfg_row(REG_SPARE_LAST, 16'h0000),
            item_row(CMD_ENQ, 2'd2, 16'h1234, 1'b0, 1),
            cfg_row(REG_ENABLE_MASK, 16'h0000),
            item_row(CMD_ENQ, 2'd3, 16'h8000, 1'b0, QUEUE_DEPTH_DEF),
            with_result(item_row(CMD_ENQ, 2'd3, 16'hBEEF, 1'b0, 1),
                        16'hBEEF, 2'd3, 1'b0, 1'b1),
            cfg_row(REG_ENABLE_MASK, 16'h000F),
            item_row(CMD_ENQ, 2'd0, 16'h0001, 1'b0, 1),
            item_row(CMD_FB,  2'd3, 16'h0000, 1'b0, 1),
            item_row(CMD_ENQ, 2'd3, 16'h7FFF, 1'b1, 1)
        };

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                for (int j = 0; j < plan[i].reps; j++)
                    send_word(plan[i].kind, plan[i].cls, plan[i].tag + TAG_BITS'(j),
                              plan[i].ok, plan[i].typed, plan[i].want);
        end

        for (int k = 0; k < NUM_PHASES; k++)
        begin
            settle();
            en_v   = pick_reg_value();
            prio_v = pick_reg_value();
            win_v  = pick_reg_value();
            rel_v  = pick_reg_value();
            if (k == 1)
                en_v = '0;
            if (k == 2)
            begin
                en_v   = '1;
                prio_v = '0;
                win_v  = '1;
                rel_v  = '1;
            end
            if (k == 3)
            begin
                prio_v = '1;
                win_v  = '0;
                rel_v  = '0;
            end
            write_reg(REG_ENABLE_MASK, en_v);
            write_reg(REG_PRIORITIES, prio_v);
            write_reg(REG_INIT_WINDOWS, win_v);
            write_reg(REG_RELIABLE_MASK, rel_v);
            idle_on = (k != 1 && k != 4);
            if (k == 2)
                hold_output = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                kind = ($urandom_range(0, 3) == 0) ? CMD_FB : CMD_ENQ;
                send_word(kind, CLS_W'($urandom_range(0, 3)), TAG_BITS'($urandom),
                          1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
        settle();

        $display("Run covered %0d input words (%0d feedback) and %0d output words, %0d drops.",
                 words_in, feedback_in, results_out, drops_out);
        $display("It made %0d register writes and %0d long output stalls; %0d mismatches.",
                 reg_writes, holds_done, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS class_priority_window_scheduler_top");
        else
            $display("FAIL class_priority_window_scheduler_top");
        $finish;
    end

endmodule
